// ===== rtl/cbsw_pkg.sv =====
// shared types and constants for the sliding-window circuit breaker
// no dependencies; imported by every module of the block
`default_nettype none

package cbsw_pkg;

  // default sizing
  localparam int unsigned MaxFailuresDef = 16;
  localparam int unsigned TimeBitsDef    = 32;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegFailThr = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSuccThr = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOpenTmo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegFailWin = 2'd3;

  // register reset values
  localparam logic [4:0]  FailThrRst = 5'd5;
  localparam logic [7:0]  SuccThrRst = 8'd3;
  localparam logic [31:0] OpenTmoRst = 32'd60;
  localparam logic [31:0] FailWinRst = 32'd60;

  typedef enum logic [1:0] {
    FN_SUCCESS = 2'd0,
    FN_FAILURE = 2'd1,
    FN_PROBE   = 2'd2,
    FN_RESET   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2
  } mode_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic walk_init;
    logic walk_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_req;
    logic walk_done;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/cbsw_ctrl.sv =====
// sequencing state machine of the circuit breaker
// depends on cbsw_pkg; drives cbsw_datapath through cmd_t, reads sts_t
`default_nettype none

module cbsw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  cbsw_pkg::sts_t     sts_i,
  output cbsw_pkg::cmd_t     cmd_o
);
  import cbsw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.walk_req) begin
          cmd_o.walk_init = 1'b1;
          state_d         = ST_WALK;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/cbsw_datapath.sv =====
// breaker state, config registers, stamp ring memory and result register
// depends on cbsw_pkg; controlled by cbsw_ctrl
`default_nettype none

module cbsw_datapath #(
  parameter int unsigned MAX_FAILURES = cbsw_pkg::MaxFailuresDef,
  parameter int unsigned TIME_BITS    = cbsw_pkg::TimeBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cbsw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [cbsw_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic [1:0]                    func_i,
  input  wire logic [31:0]                   now_time_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic [1:0]                         breaker_state_o,
  output logic                               probe_granted_o,
  output logic [4:0]                         failure_count_o,
  output logic [7:0]                         success_count_o,
  input  cbsw_pkg::cmd_t                     cmd_i,
  output cbsw_pkg::sts_t                     sts_o
);
  import cbsw_pkg::*;

  localparam int unsigned TW   = TIME_BITS;
  localparam int unsigned IW   = (MAX_FAILURES > 1) ? $clog2(MAX_FAILURES) : 1;
  localparam int unsigned CNTW = $clog2(MAX_FAILURES + 1);
  localparam int unsigned SW   = ((IW > CNTW) ? IW : CNTW) + 1;
  localparam int unsigned CW   = (TW > 32) ? TW : 32;
  localparam int unsigned FW   = (CNTW > 5) ? CNTW : 5;

  // ring index of head + k, k below the ring depth
  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] head,
                                             input logic [CNTW-1:0] k);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(k);
    if (sum >= SW'(MAX_FAILURES)) begin
      sum = sum - SW'(MAX_FAILURES);
    end
    return IW'(sum);
  endfunction

  // config registers
  logic [4:0]  fthr_q;
  logic [7:0]  sthr_q;
  logic [31:0] tmo_q;
  logic [31:0] win_q;

  // event being processed
  func_e         func_q;
  logic [TW-1:0] now_q;

  // breaker state
  mode_e           mode_q, mode_d;
  logic [IW-1:0]   head_q, head_d;
  logic [CNTW-1:0] fill_q, fill_d;
  logic [7:0]      succ_q, succ_d;
  logic [TW-1:0]   opened_q, opened_d;
  logic            granted_d;

  // expiry walk
  logic [CNTW-1:0] rk_q, kept_q, n_q;
  logic            rv_q;
  logic [TW-1:0]   rdata_q;
  logic            rd_issue, keep, cmp_wr, push;
  logic [IW-1:0]   raddr, waddr;
  logic [TW-1:0]   age, wdata;
  logic            mem_we;
  logic            full;

  // result register
  logic        out_valid_q;
  mode_e       out_state_q;
  logic        out_granted_q;
  logic [4:0]  out_fail_q;
  logic [7:0]  out_succ_q;

  logic [TW-1:0] ring_mem [MAX_FAILURES];

  // walk datapath
  assign full     = (fill_q == CNTW'(MAX_FAILURES));
  assign rd_issue = cmd_i.walk_step && (rk_q < n_q);
  assign raddr    = ring_add(head_q, rk_q);
  assign waddr    = ring_add(head_q, kept_q);
  assign age      = TW'(now_q - rdata_q);
  assign keep     = (CW'(age) <= CW'(win_q));
  assign cmp_wr   = rv_q && keep;
  assign push     = (func_q == FN_FAILURE) && (mode_q == MODE_CLOSED);
  assign mem_we   = cmp_wr || (cmd_i.finish && push);
  assign wdata    = rv_q ? rdata_q : now_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rdata_q <= ring_mem[raddr];
    end
  end

  // end-of-event update
  always_comb begin
    logic [7:0]      succ_inc;
    logic [CNTW-1:0] new_fill;
    mode_d    = mode_q;
    head_d    = head_q;
    fill_d    = fill_q;
    succ_d    = succ_q;
    opened_d  = opened_q;
    granted_d = 1'b0;
    succ_inc  = (succ_q != 8'hFF) ? succ_q + 8'd1 : succ_q;
    new_fill  = kept_q + CNTW'(1);
    unique case (func_q)
      FN_SUCCESS: begin
        if (mode_q == MODE_HALF) begin
          if (succ_inc >= sthr_q) begin
            mode_d = MODE_CLOSED;
            head_d = '0;
            fill_d = '0;
            succ_d = '0;
          end else begin
            succ_d = succ_inc;
          end
        end else if (mode_q == MODE_CLOSED) begin
          head_d = '0;
          fill_d = '0;
        end
      end
      FN_FAILURE: begin
        if (mode_q == MODE_HALF) begin
          mode_d   = MODE_OPEN;
          opened_d = now_q;
        end else if (mode_q == MODE_CLOSED) begin
          fill_d = new_fill;
          // threshold above the ring depth saturates at a full ring
          if ((FW'(new_fill) >= FW'(fthr_q)) || (new_fill == CNTW'(MAX_FAILURES))) begin
            mode_d   = MODE_OPEN;
            opened_d = now_q;
          end
        end
      end
      FN_PROBE: begin
        if ((mode_q == MODE_OPEN) && (CW'(TW'(now_q - opened_q)) >= CW'(tmo_q))) begin
          mode_d    = MODE_HALF;
          succ_d    = '0;
          granted_d = 1'b1;
        end
      end
      FN_RESET: begin
        mode_d = MODE_CLOSED;
        head_d = '0;
        fill_d = '0;
        succ_d = '0;
      end
      default: mode_d = mode_q;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fthr_q      <= FailThrRst;
      sthr_q      <= SuccThrRst;
      tmo_q       <= OpenTmoRst;
      win_q       <= FailWinRst;
      mode_q      <= MODE_CLOSED;
      head_q      <= '0;
      fill_q      <= '0;
      succ_q      <= '0;
      opened_q    <= '0;
      rk_q        <= '0;
      kept_q      <= '0;
      n_q         <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegFailThr: fthr_q <= cfg_data_i[4:0];
          RegSuccThr: sthr_q <= cfg_data_i[7:0];
          RegOpenTmo: tmo_q  <= cfg_data_i;
          RegFailWin: win_q  <= cfg_data_i;
          default:    fthr_q <= fthr_q;
        endcase
      end
      rv_q <= rd_issue;
      if (cmd_i.walk_init) begin
        // a full ring drops its oldest stamp before the walk
        head_q <= full ? ring_add(head_q, CNTW'(1)) : head_q;
        n_q    <= full ? CNTW'(MAX_FAILURES - 1) : fill_q;
        rk_q   <= '0;
        kept_q <= '0;
      end else begin
        if (rd_issue) begin
          rk_q <= rk_q + CNTW'(1);
        end
        if (cmp_wr) begin
          kept_q <= kept_q + CNTW'(1);
        end
      end
      if (cmd_i.finish) begin
        mode_q   <= mode_d;
        head_q   <= head_d;
        fill_q   <= fill_d;
        succ_q   <= succ_d;
        opened_q <= opened_d;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_e'(func_i);
      now_q  <= TW'(now_time_i);
    end
    if (cmd_i.finish) begin
      out_state_q   <= mode_d;
      out_granted_q <= granted_d;
      out_fail_q    <= 5'(fill_d);
      out_succ_q    <= succ_d;
    end
  end

  assign sts_o.walk_req  = push;
  assign sts_o.walk_done = (rk_q == n_q) && !rv_q;
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign breaker_state_o = out_state_q;
  assign probe_granted_o = out_granted_q;
  assign failure_count_o = out_fail_q;
  assign success_count_o = out_succ_q;

`ifndef SYNTHESIS
  a_kept_le_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= rk_q)
    else $error("walk kept more stamps than it read");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNTW'(MAX_FAILURES))
    else $error("ring fill beyond depth");

  a_grant_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_granted_q |-> out_state_q == MODE_HALF)
    else $error("granted probe without half-open state");
`endif

endmodule

`default_nettype wire

// ===== rtl/circuit_breaker_sliding_window.sv =====
// an event is accepted in idle and passes exec, then finish; a failure while closed also takes
// the expiry walk between exec and finish, over n live stamps (1 to MAX_FAILURES-1),
//   or over none when the ring is empty
// a new event is taken only after the last has finished; the walk reads one ring entry per cycle
// reset: async active low, breaker closed, ring empty, counters zero, registers at defaults,
// ring memory holds no reset value and needs no clearing pass
`default_nettype none

module circuit_breaker_sliding_window #(
  parameter int unsigned MAX_FAILURES = cbsw_pkg::MaxFailuresDef,
  parameter int unsigned TIME_BITS    = cbsw_pkg::TimeBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [cbsw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [cbsw_pkg::CfgDataW-1:0] cfg_data_i,
  // event input
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [31:0]                   now_time_i,
  // result output
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         breaker_state_o,
  output logic                               probe_granted_o,
  output logic [4:0]                         failure_count_o,
  output logic [7:0]                         success_count_o
);
  import cbsw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller: idle -> exec -> (walk) -> finish -> idle
  // exec decides whether the event needs the expiry walk (failure while closed)
  // finish waits while an earlier result still sits in the output register
  cbsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: breaker mode, stamp ring, expiry walk and result register
  // the walk compacts surviving stamps toward the head, the new stamp is
  // appended last since its own age is always zero
  cbsw_datapath #(
    .MAX_FAILURES (MAX_FAILURES),
    .TIME_BITS    (TIME_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (func_i),
    .now_time_i      (now_time_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .breaker_state_o (breaker_state_o),
    .probe_granted_o (probe_granted_o),
    .failure_count_o (failure_count_o),
    .success_count_o (success_count_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

`default_nettype wire
